// ===== hdl/hbia_pkg.sv =====
// shared types and codes of the hierarchical bitmap index allocator
`timescale 1ns / 1ps
package hbia_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } hbia_kind_t;

  typedef enum logic [1:0] {
    LVL_L2   = 2'd0,
    LVL_L3   = 2'd1,
    LVL_LEAF = 2'd2
  } hbia_lvl_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_A_L2,
    ST_A_L3,
    ST_A_LEAF,
    ST_A_WR,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_RESP
  } hbia_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] slot;
  } hbia_in_t;

  typedef struct packed {
    logic [15:0] granted_slot;
    logic        ok;
    logic [16:0] used_count;
  } hbia_out_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic alloc_l2;
    logic alloc_l3;
    logic alloc_leaf;
    logic alloc_wr;
    logic div;
    logic rd;
    logic chk;
    logic res_load;
  } hbia_cmd_t;

  typedef struct packed {
    hbia_kind_t in_kind;
    hbia_kind_t kind;
    hbia_lvl_t  lvl;
    logic       root_full;
    logic       l2_full;
    logic       l3_full;
    logic       lvl_full;
    logic       leaf_bit;
    logic       oob;
    logic       clr_last;
  } hbia_sts_t;

endpackage

// ===== hdl/hbia_ctrl.sv =====
// sequencing state machine of the allocator
`timescale 1ns / 1ps
module hbia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hbia_pkg::hbia_cmd_t cmd,
  input  hbia_pkg::hbia_sts_t sts
);
  import hbia_pkg::*;

  hbia_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        clr_cmd_r, clr_cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (sts.clr_last) state_nxt = clr_cmd_r ? ST_RESP : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.in_kind)
            KIND_ALLOC: state_nxt = ST_A_L2;
            KIND_FREE:  state_nxt = ST_DIV;
            KIND_QUERY: state_nxt = ST_DIV;
            KIND_CLEAR: state_nxt = ST_CLR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_A_L2:   state_nxt = sts.root_full ? ST_RESP : ST_A_L3;
      ST_A_L3:   state_nxt = sts.l2_full ? ST_RESP : ST_A_LEAF;
      ST_A_LEAF: state_nxt = sts.l3_full ? ST_RESP : ST_A_WR;
      ST_A_WR:   state_nxt = ST_RESP;
      ST_DIV:    state_nxt = sts.oob ? ST_RESP : ST_RD;
      ST_RD:     state_nxt = ST_CHK;
      ST_CHK: begin
        priority if (sts.lvl == LVL_LEAF &&
                     (sts.kind == KIND_QUERY || !sts.leaf_bit)) state_nxt = ST_RESP;
        else if (sts.lvl_full && sts.lvl != LVL_L2) state_nxt = ST_DIV;
        else state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_CLR:    cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_A_L2:   cmd.alloc_l2 = 1'b1;
      ST_A_L3:   cmd.alloc_l3 = 1'b1;
      ST_A_LEAF: cmd.alloc_leaf = 1'b1;
      ST_A_WR:   cmd.alloc_wr = 1'b1;
      ST_DIV:    cmd.div = 1'b1;
      ST_RD:     cmd.rd = 1'b1;
      ST_CHK:    cmd.chk = 1'b1;
      ST_RESP:   cmd.res_load = !out_valid_r || out_ready;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    clr_cmd_nxt = clr_cmd_r;
    if (cmd.load) clr_cmd_nxt = (sts.in_kind == KIND_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      clr_cmd_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r != ST_IDLE)
    else $error("accepted word left controller idle");
  a_resp_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

endmodule

// ===== hdl/hbia_dp.sv =====
// bitmap memories, index arithmetic and result register of the allocator
`timescale 1ns / 1ps
module hbia_dp #(
  parameter int WORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hbia_pkg::hbia_in_t  in_word,
  output hbia_pkg::hbia_out_t out_word,
  input  hbia_pkg::hbia_cmd_t cmd,
  output hbia_pkg::hbia_sts_t sts
);
  import hbia_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int LW  = $clog2(W);
  localparam int L3D = W * W;
  localparam int L4D = W * W * W;
  localparam int A3W = $clog2(L3D);
  localparam int A4W = $clog2(L4D);
  localparam longint unsigned CAP = longint'(W) * W * W * W;
  localparam int SW   = $clog2(CAP);
  localparam int CNTW = $clog2(CAP + 1);
  localparam int XW   = (A4W > 16) ? A4W : 16;
  localparam int K    = XW + LW;
  localparam longint unsigned RECIP = ((64'd1 << K) + W - 1) / W;

  localparam logic [W-1:0] FULL = {W{1'b1}};

  function automatic logic [LW-1:0] lz(input logic [W-1:0] w);
    logic [LW-1:0] r;
    r = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (!w[i]) r = LW'(i);
    end
    return r;
  endfunction

  function automatic logic [W-1:0] bit_of(input logic [LW-1:0] b);
    return W'(1) << b;
  endfunction

  // storage
  logic [W-1:0] l2_mem   [W];
  logic [W-1:0] l3_mem   [L3D];
  logic [W-1:0] leaf_mem [L4D];
  logic [W-1:0] l2_q, l3_q, leaf_q;
  logic [W-1:0] root_r;

  hbia_kind_t      kind_r;
  hbia_lvl_t       lvl_r;
  logic            oob_r;
  logic [XW-1:0]   x_r, q_r, idx_r;
  logic [LW-1:0]   b_r, b1_r, b2_r, b3_r;
  logic [A3W-1:0]  i3_r;
  logic [A4W-1:0]  i4_r, clr_idx_r;
  logic [CNTW-1:0] count_r;
  logic [15:0]     res_granted_r;
  logic            res_ok_r;
  hbia_out_t       out_word_r;

  // memory ports
  logic            l2_re, l3_re, leaf_re, l2_we, l3_we, leaf_we;
  logic [LW-1:0]   l2_ra, l2_wa;
  logic [A3W-1:0]  l3_ra, l3_wa;
  logic [A4W-1:0]  leaf_ra, leaf_wa;
  logic [W-1:0]    l2_wd, l3_wd, leaf_wd;

  // allocation path
  logic [LW-1:0]    b1, b2, b3, b4;
  logic [A3W-1:0]   i3;
  logic [A4W-1:0]   i4;
  logic [W-1:0]     new_leaf, new3, new2;
  logic             full4, full3, full2;
  logic [SW-1:0]    gsum;
  logic [XW+K-1:0]  prod;
  logic [XW-1:0]    rem_w;
  logic [W-1:0]     cur_q, mask;
  logic             leaf_bit, cur_full;

  assign b1 = lz(root_r);
  assign b2 = lz(l2_q);
  assign b3 = lz(l3_q);
  assign b4 = lz(leaf_q);
  assign i3 = A3W'(A3W'(b1_r) * A3W'(W)) + A3W'(b2);
  assign i4 = A4W'(A4W'(i3_r) * A4W'(W)) + A4W'(b3);

  assign new_leaf = leaf_q | bit_of(b4);
  assign full4    = (new_leaf == FULL);
  assign new3     = l3_q | (full4 ? bit_of(b3_r) : '0);
  assign full3    = full4 && (new3 == FULL);
  assign new2     = l2_q | (full3 ? bit_of(b2_r) : '0);
  assign full2    = full3 && (new2 == FULL);
  assign gsum     = SW'(SW'(i4_r) * SW'(W)) + SW'(b4);

  // constant division by W through a reciprocal, exact over the index range
  assign prod  = (XW+K)'(x_r) * (XW+K)'(RECIP);
  assign rem_w = x_r - XW'(q_r * XW'(W));

  // release path
  assign mask     = bit_of(b_r);
  assign leaf_bit = leaf_q[b_r];
  always_comb begin
    unique case (lvl_r)
      LVL_L2:   cur_q = l2_q;
      LVL_L3:   cur_q = l3_q;
      LVL_LEAF: cur_q = leaf_q;
      default:  cur_q = leaf_q;
    endcase
  end
  assign cur_full = (cur_q == FULL);

  always_comb begin
    l2_re = 1'b0;  l2_ra = b1;
    l3_re = 1'b0;  l3_ra = i3;
    leaf_re = 1'b0; leaf_ra = i4;
    if (cmd.alloc_l2) l2_re = 1'b1;
    if (cmd.alloc_l3) l3_re = 1'b1;
    if (cmd.alloc_leaf) leaf_re = 1'b1;
    if (cmd.rd) begin
      unique case (lvl_r)
        LVL_L2: begin
          l2_re = 1'b1; l2_ra = q_r[LW-1:0];
        end
        LVL_L3: begin
          l3_re = 1'b1; l3_ra = q_r[A3W-1:0];
        end
        LVL_LEAF: begin
          leaf_re = 1'b1; leaf_ra = q_r[A4W-1:0];
        end
        default: leaf_re = 1'b0;
      endcase
    end
  end

  always_comb begin
    l2_we = 1'b0;   l2_wa = idx_r[LW-1:0];    l2_wd = l2_q & ~mask;
    l3_we = 1'b0;   l3_wa = idx_r[A3W-1:0];   l3_wd = l3_q & ~mask;
    leaf_we = 1'b0; leaf_wa = idx_r[A4W-1:0]; leaf_wd = leaf_q & ~mask;
    priority if (cmd.clr_step) begin
      leaf_we = 1'b1; leaf_wa = clr_idx_r; leaf_wd = '0;
      l3_we = (clr_idx_r < A4W'(L3D)); l3_wa = clr_idx_r[A3W-1:0]; l3_wd = '0;
      l2_we = (clr_idx_r < A4W'(W));   l2_wa = clr_idx_r[LW-1:0];  l2_wd = '0;
    end else if (cmd.alloc_wr) begin
      if (leaf_q != FULL) begin
        leaf_we = 1'b1; leaf_wa = i4_r; leaf_wd = new_leaf;
        l3_we = full4;  l3_wa = i3_r;  l3_wd = new3;
        l2_we = full3;  l2_wa = b1_r;  l2_wd = new2;
      end
    end else if (cmd.chk) begin
      unique case (lvl_r)
        LVL_LEAF: leaf_we = (kind_r == KIND_FREE) && leaf_bit;
        LVL_L3:   l3_we = 1'b1;
        LVL_L2:   l2_we = 1'b1;
        default:  leaf_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_wa] <= l2_wd;
    if (l2_re) l2_q <= l2_mem[l2_ra];
    if (l3_we) l3_mem[l3_wa] <= l3_wd;
    if (l3_re) l3_q <= l3_mem[l3_ra];
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    if (leaf_re) leaf_q <= leaf_mem[leaf_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      count_r   <= '0;
      root_r    <= '0;
      lvl_r     <= LVL_LEAF;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= (clr_idx_r == A4W'(L4D - 1)) ? '0 : clr_idx_r + 1'b1;
        count_r   <= '0;
        root_r    <= '0;
      end
      if (cmd.load) lvl_r <= LVL_LEAF;
      if (cmd.alloc_wr && leaf_q != FULL) begin
        count_r <= count_r + 1'b1;
        if (full2) root_r <= root_r | bit_of(b1_r);
      end
      if (cmd.chk) begin
        unique case (lvl_r)
          LVL_LEAF: begin
            if (kind_r == KIND_FREE && leaf_bit) begin
              count_r <= count_r - 1'b1;
              if (cur_full) lvl_r <= LVL_L3;
            end
          end
          LVL_L3: if (cur_full) lvl_r <= LVL_L2;
          LVL_L2: if (cur_full) root_r <= root_r & ~bit_of(idx_r[LW-1:0]);
          default: lvl_r <= LVL_LEAF;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r        <= hbia_kind_t'(in_word.kind);
      x_r           <= XW'(in_word.slot);
      oob_r         <= 64'(in_word.slot) >= 64'(CAP);
      res_granted_r <= '0;
      res_ok_r      <= (hbia_kind_t'(in_word.kind) == KIND_CLEAR);
    end
    if (cmd.alloc_l2) b1_r <= b1;
    if (cmd.alloc_l3) begin
      b2_r <= b2;
      i3_r <= i3;
    end
    if (cmd.alloc_leaf) begin
      b3_r <= b3;
      i4_r <= i4;
    end
    if (cmd.alloc_wr && leaf_q != FULL) begin
      res_granted_r <= 16'(gsum);
      res_ok_r      <= 1'b1;
    end
    if (cmd.div) q_r <= prod[XW+K-1:K];
    if (cmd.rd) begin
      idx_r <= q_r;
      b_r   <= rem_w[LW-1:0];
    end
    if (cmd.chk) begin
      if (lvl_r == LVL_LEAF) res_ok_r <= leaf_bit;
      if (cur_full) x_r <= idx_r;
    end
    if (cmd.res_load) begin
      out_word_r.granted_slot <= res_granted_r;
      out_word_r.ok           <= res_ok_r;
      out_word_r.used_count   <= 17'(count_r);
    end
  end

  assign out_word = out_word_r;

  always_comb begin
    sts           = '0;
    sts.in_kind   = hbia_kind_t'(in_word.kind);
    sts.kind      = kind_r;
    sts.lvl       = lvl_r;
    sts.root_full = (root_r == FULL);
    sts.l2_full   = (l2_q == FULL);
    sts.l3_full   = (l3_q == FULL);
    sts.lvl_full  = cur_full;
    sts.leaf_bit  = leaf_bit;
    sts.oob       = oob_r;
    sts.clr_last  = (clr_idx_r == A4W'(L4D - 1));
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    64'(count_r) <= 64'(CAP))
    else $error("used count above capacity");
  a_free_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.chk && lvl_r == LVL_LEAF && kind_r == KIND_FREE && leaf_bit)
    |=> count_r == $past(count_r) - 1'b1)
    else $error("successful free did not decrement count");

endmodule

// ===== hdl/hierarchical_bitmap_index_allocator.sv =====
// top level of the four-level hierarchical bitmap index allocator
`timescale 1ns / 1ps
// usage
//   in channel: in_word carries kind (allocate, free, query, clear) and slot
//   out channel: out_word carries granted_slot, ok and used_count; one
//   result word for every input word, in order
//   the maps live in three one-port memories (level 2, level 3, leaf) plus a
//   root register; the sequencer walks them one read at a time
// steps
//   allocate: the root, three dependent reads and one write-back step that
//   updates the leaf and every upper level it fills, at once
//   query: one level step at the leaf; free: the same, plus one per upper
//   level whose full mark is cleared; each level step is a divide by the
//   word width through a reciprocal multiply, then a memory read
//   one word is in work at a time; the next is taken when the sequencer is
//   back in idle
// reset and clear
//   after reset and after a clear command a pass zeroes one leaf word per
//   cycle, WORD_BITS**3 words (4096 at the default width); in_ready is low
//   during the pass; the pass after reset gives no result word
// stall
//   a finished result waits in the output register until out_ready takes it;
//   the sequencer holds the next one until then, not the work on the item
module hierarchical_bitmap_index_allocator #(
  parameter int WORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hbia_pkg::hbia_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output hbia_pkg::hbia_out_t out_word
);
  import hbia_pkg::*;

  // command and status between sequencer and datapath
  hbia_cmd_t cmd;
  hbia_sts_t sts;

  hbia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hbia_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
